>>> rtl/core/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, depths, status codes and register indexes for the
// two-region page allocator.
// ----------------------------------------------------------------------------
package tpa_pkg;

  // page and address geometry
  localparam int ADDR_W    = 56;
  localparam int PAGE_BITS = 12;
  localparam int PN_W      = ADDR_W - PAGE_BITS;

  // stack depths and count / index widths
  localparam int KERNEL_DEPTH = 1024;
  localparam int USER_DEPTH   = 32768;
  localparam int KIDX_W       = (KERNEL_DEPTH > 1) ? $clog2(KERNEL_DEPTH) : 1;
  localparam int UIDX_W       = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
  localparam int KCNT_W       = $clog2(KERNEL_DEPTH + 1);
  localparam int UCNT_W       = $clog2(USER_DEPTH + 1);
  localparam int FREE_W       = 16;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_KERNEL_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_USER_LIMIT   = 2'd2;

  localparam logic [ADDR_W-1:0] KERNEL_BASE_RST  = 56'h0000_0080_000000;
  localparam logic [ADDR_W-1:0] KERNEL_LIMIT_RST = 56'h0000_0080_400000;
  localparam logic [ADDR_W-1:0] USER_LIMIT_RST   = 56'h0000_0088_000000;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADADDR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;  // capture request fields
    logic exec;   // perform the stack operation
  } tpa_cmd_t;

endpackage

>>> rtl/core/tpa_ram.sv
// ----------------------------------------------------------------------------
// tpa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/tpa_ctrl.sv
// ----------------------------------------------------------------------------
// tpa_ctrl
// Request sequencer: accept, execute, respond. A new request may be taken
// in the respond cycle.
// ----------------------------------------------------------------------------
module tpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output tpa_pkg::tpa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  // busy only while the stack operation runs
  assign busy      = (state == S_EXEC);
  assign done      = (state == S_RESP);
  assign cmd.latch = start && !busy;
  assign cmd.exec  = (state == S_EXEC);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/tpa_dp.sv
// ----------------------------------------------------------------------------
// tpa_dp
// Datapath: region registers, address check, free counts and the two
// page-number stacks.
// ----------------------------------------------------------------------------
module tpa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  tpa_pkg::tpa_cmd_t                  cmd,
  input  logic                               func,
  input  logic                               kernel_side,
  input  logic [tpa_pkg::ADDR_W-1:0]         page_addr,
  input  logic                               cfg_we,
  input  logic [tpa_pkg::REG_IDX_W-1:0]      cfg_idx,
  input  logic [tpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [tpa_pkg::CFG_DATA_W-1:0]     cfg_rdata,
  output logic [1:0]                         status,
  output logic [tpa_pkg::ADDR_W-1:0]         granted_addr,
  output logic [tpa_pkg::FREE_W-1:0]         pages_free
);

  logic [tpa_pkg::ADDR_W-1:0] kernel_base;
  logic [tpa_pkg::ADDR_W-1:0] kernel_limit;
  logic [tpa_pkg::ADDR_W-1:0] user_limit;

  logic                       func_q;
  logic                       kside_q;
  logic [tpa_pkg::ADDR_W-1:0] addr_q;

  logic [tpa_pkg::KCNT_W-1:0] kernel_count;
  logic [tpa_pkg::UCNT_W-1:0] user_count;

  tpa_pkg::status_t           status_q;
  logic [tpa_pkg::FREE_W-1:0] free_q;
  logic                       granted_q;

  logic [tpa_pkg::ADDR_W-1:0] lo;
  logic [tpa_pkg::ADDR_W-1:0] hi;
  logic                       addr_ok;
  logic                       k_full;
  logic                       u_full;
  logic                       k_empty;
  logic                       u_empty;
  logic                       full;
  logic                       empty;
  logic                       do_push;
  logic                       do_pop;
  tpa_pkg::status_t           status_next;
  logic [tpa_pkg::KCNT_W-1:0] kernel_count_next;
  logic [tpa_pkg::UCNT_W-1:0] user_count_next;
  logic [tpa_pkg::KCNT_W-1:0] k_dec;
  logic [tpa_pkg::UCNT_W-1:0] u_dec;

  logic                       k_we;
  logic                       k_re;
  logic [tpa_pkg::KIDX_W-1:0] k_addr;
  logic [tpa_pkg::PN_W-1:0]   k_rdata;
  logic                       u_we;
  logic                       u_re;
  logic [tpa_pkg::UIDX_W-1:0] u_addr;
  logic [tpa_pkg::PN_W-1:0]   u_rdata;
  logic [tpa_pkg::PN_W-1:0]   pn_rd;
  logic [tpa_pkg::PN_W-1:0]   pn_wr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_base  <= tpa_pkg::KERNEL_BASE_RST;
      kernel_limit <= tpa_pkg::KERNEL_LIMIT_RST;
      user_limit   <= tpa_pkg::USER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tpa_pkg::REG_KERNEL_BASE:  kernel_base  <= cfg_wdata[tpa_pkg::ADDR_W-1:0];
        tpa_pkg::REG_KERNEL_LIMIT: kernel_limit <= cfg_wdata[tpa_pkg::ADDR_W-1:0];
        tpa_pkg::REG_USER_LIMIT:   user_limit   <= cfg_wdata[tpa_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    cfg_rdata = '0;
    case (cfg_idx)
      tpa_pkg::REG_KERNEL_BASE:  cfg_rdata[tpa_pkg::ADDR_W-1:0] = kernel_base;
      tpa_pkg::REG_KERNEL_LIMIT: cfg_rdata[tpa_pkg::ADDR_W-1:0] = kernel_limit;
      tpa_pkg::REG_USER_LIMIT:   cfg_rdata[tpa_pkg::ADDR_W-1:0] = user_limit;
      default:                   cfg_rdata = '0;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q  <= func;
      kside_q <= kernel_side;
      addr_q  <= page_addr;
    end
  end

  // region bounds and address check
  assign lo      = kside_q ? kernel_base : kernel_limit;
  assign hi      = kside_q ? kernel_limit : user_limit;
  assign addr_ok = (addr_q[tpa_pkg::PAGE_BITS-1:0] == '0) && (addr_q >= lo) && (addr_q < hi);

  assign k_full  = (kernel_count == tpa_pkg::KCNT_W'(tpa_pkg::KERNEL_DEPTH));
  assign u_full  = (user_count == tpa_pkg::UCNT_W'(tpa_pkg::USER_DEPTH));
  assign k_empty = (kernel_count == '0);
  assign u_empty = (user_count == '0);
  assign full    = kside_q ? k_full : u_full;
  assign empty   = kside_q ? k_empty : u_empty;
  assign k_dec   = kernel_count - 1'b1;
  assign u_dec   = user_count - 1'b1;

  // operation decision
  always_comb begin
    do_push     = 1'b0;
    do_pop      = 1'b0;
    status_next = tpa_pkg::ST_OK;
    if (func_q == tpa_pkg::FUNC_FREE) begin
      if (!addr_ok) begin
        status_next = tpa_pkg::ST_BADADDR;
      end else if (full) begin
        status_next = tpa_pkg::ST_OVERFLOW;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = tpa_pkg::ST_EMPTY;
      end else begin
        do_pop = 1'b1;
      end
    end
  end

  // count updates
  always_comb begin
    kernel_count_next = kernel_count;
    user_count_next   = user_count;
    if (kside_q) begin
      if (do_push) kernel_count_next = kernel_count + 1'b1;
      if (do_pop)  kernel_count_next = k_dec;
    end else begin
      if (do_push) user_count_next = user_count + 1'b1;
      if (do_pop)  user_count_next = u_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_count <= '0;
      user_count   <= '0;
    end else if (cmd.exec) begin
      kernel_count <= kernel_count_next;
      user_count   <= user_count_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q  <= status_next;
      granted_q <= do_pop;
      free_q    <= kside_q ? tpa_pkg::FREE_W'(kernel_count_next)
                           : tpa_pkg::FREE_W'(user_count_next);
    end
  end

  // stack memory ports: push at count, pop at count minus one
  assign pn_wr  = addr_q[tpa_pkg::ADDR_W-1:tpa_pkg::PAGE_BITS];
  assign k_we   = cmd.exec && kside_q && do_push;
  assign k_re   = cmd.exec && kside_q && do_pop;
  assign k_addr = do_push ? kernel_count[tpa_pkg::KIDX_W-1:0] : k_dec[tpa_pkg::KIDX_W-1:0];
  assign u_we   = cmd.exec && !kside_q && do_push;
  assign u_re   = cmd.exec && !kside_q && do_pop;
  assign u_addr = do_push ? user_count[tpa_pkg::UIDX_W-1:0] : u_dec[tpa_pkg::UIDX_W-1:0];

  tpa_ram #(
    .WIDTH (tpa_pkg::PN_W),
    .DEPTH (tpa_pkg::KERNEL_DEPTH)
  ) u_kernel_stack (
    .clk   (clk),
    .we    (k_we),
    .re    (k_re),
    .addr  (k_addr),
    .wdata (pn_wr),
    .rdata (k_rdata)
  );

  tpa_ram #(
    .WIDTH (tpa_pkg::PN_W),
    .DEPTH (tpa_pkg::USER_DEPTH)
  ) u_user_stack (
    .clk   (clk),
    .we    (u_we),
    .re    (u_re),
    .addr  (u_addr),
    .wdata (pn_wr),
    .rdata (u_rdata)
  );

  // result fields
  assign pn_rd        = kside_q ? k_rdata : u_rdata;
  assign status       = status_q;
  assign pages_free   = free_q;
  assign granted_addr = granted_q ? {pn_rd, {tpa_pkg::PAGE_BITS{1'b0}}} : '0;

endmodule

>>> rtl/core/two_region_page_allocator.sv
// ----------------------------------------------------------------------------
// two_region_page_allocator
// Kernel and user page allocator, each region a LIFO stack of free pages.
// ----------------------------------------------------------------------------
// done is high in the respond state, which follows the execute state entered at
//   the accepting edge; the result is taken at the edge that ends it
// a new request can be taken in the respond state, but not in the execute state
//   (execute cycle, then registered read data in the respond cycle)
// the receiver cannot stall; done is high for exactly one cycle per request
// reset: synchronous, clears both counts and restores the region registers;
//   stack contents are left as they are
module two_region_page_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func,
  input  logic                              kernel_side,
  input  logic [tpa_pkg::ADDR_W-1:0]        page_addr,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [tpa_pkg::ADDR_W-1:0]        granted_addr,
  output logic [tpa_pkg::FREE_W-1:0]        pages_free,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tpa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tpa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  tpa_pkg::tpa_cmd_t cmd;
  logic              cfg_we;

  // register write on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  tpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tpa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .kernel_side  (kernel_side),
    .page_addr    (page_addr),
    .cfg_we       (cfg_we),
    .cfg_idx      (paddr[tpa_pkg::CFG_ADDR_W-1:3]),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata),
    .status       (status),
    .granted_addr (granted_addr),
    .pages_free   (pages_free)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-region page allocator. A directed table
// covers reset state, region edges, LIFO order, double free and the page at
// address zero. Randomized phases then run under many region settings.
// Every result is compared against an in-bench model of the two free-page
// stacks or, for typed directed rows, against the values given in the table.
// ----------------------------------------------------------------------------
module tb;
  import tpa_pkg::*;

  localparam logic [63:0] PAGE_SIZE   = 64'd1 << PAGE_BITS;
  localparam logic        KERNEL      = 1'b1;
  localparam logic        USER        = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASES      = 14;
  localparam int          PHASE_ITEMS = 60;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   granted;
    logic [FREE_W-1:0]   pages;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_REQ_TYPED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   f;
    logic                   k;
    logic [REG_IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]      a;     // page address, or register value
    alloc_result_t          want;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    func;
  logic                    kernel_side;
  logic [ADDR_W-1:0]       page_addr;
  logic                    done;
  logic [1:0]              status;
  logic [ADDR_W-1:0]       granted_addr;
  logic [FREE_W-1:0]       pages_free;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  // model state: region registers and the two free-page stacks
  logic [ADDR_W-1:0]       kbase;
  logic [ADDR_W-1:0]       klimit;
  logic [ADDR_W-1:0]       ulimit;
  logic [PN_W-1:0]         kstack [KERNEL_DEPTH];
  logic [PN_W-1:0]         ustack [USER_DEPTH];
  int                      kcount;
  int                      ucount;

  alloc_result_t           expected_grants [$];
  stim_row_t               directed_rows [$];
  alloc_result_t           head;

  int errors;
  int n_requests;
  int n_results;
  int n_reg_writes;
  int n_by_status [4];
  int stall_cycles;

  two_region_page_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .kernel_side  (kernel_side),
    .page_addr    (page_addr),
    .done         (done),
    .status       (status),
    .granted_addr (granted_addr),
    .pages_free   (pages_free),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one allocate or free step of the page stacks
  function automatic alloc_result_t allocate_or_free(input logic f, input logic k,
                                                     input logic [ADDR_W-1:0] a);
    alloc_result_t     r;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [PN_W-1:0]   pn;
    int                cnt;
    int                depth;
    lo    = k ? kbase : klimit;
    hi    = k ? klimit : ulimit;
    cnt   = k ? kcount : ucount;
    depth = k ? KERNEL_DEPTH : USER_DEPTH;
    r.status  = ST_OK;
    r.granted = '0;
    if (f == FUNC_FREE) begin
      if (a[PAGE_BITS-1:0] != '0 || a < lo || a >= hi) begin
        r.status = ST_BADADDR;
      end else if (cnt >= depth) begin
        r.status = ST_OVERFLOW;
      end else begin
        if (k) kstack[cnt] = a[ADDR_W-1:PAGE_BITS];
        else ustack[cnt] = a[ADDR_W-1:PAGE_BITS];
        cnt++;
      end
    end else begin
      if (cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        cnt--;
        pn = k ? kstack[cnt] : ustack[cnt];
        r.granted = {pn, {PAGE_BITS{1'b0}}};
      end
    end
    if (k) kcount = cnt;
    else ucount = cnt;
    r.pages = cnt[FREE_W-1:0];
    return r;
  endfunction

  // page address for a request: mostly valid pages, some edges and noise
  function automatic logic [ADDR_W-1:0] pick_page_addr(input logic k,
                                                       input bit valid_only);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] first;
    logic [63:0] pages;
    logic [63:0] r;
    logic [63:0] pick;
    int          sel;
    lo    = k ? kbase : klimit;
    hi    = k ? klimit : ulimit;
    first = (lo + PAGE_SIZE - 1) & ~(PAGE_SIZE - 1);
    pages = (first >= hi) ? 64'd0 : ((hi - 1 - first) >> PAGE_BITS) + 1;
    r     = {$urandom, $urandom};
    sel   = valid_only ? 99 : $urandom_range(99);
    if (sel < 20) begin
      pick = r;
    end else if (sel < 35) begin
      case (r[1:0])
        2'd0: pick = lo;
        2'd1: pick = hi;
        2'd2: pick = lo - PAGE_SIZE;
        default: pick = (pages == 0) ? first : first + ((pages - 1) << PAGE_BITS);
      endcase
    end else if (pages == 0) begin
      pick = r;
    end else if (sel < 45) begin
      // misaligned address inside the region
      pick = first + ((r % pages) << PAGE_BITS) + {r[63:53], 1'b1};
    end else begin
      pick = first + ((r % pages) << PAGE_BITS);
    end
    return pick[ADDR_W-1:0];
  endfunction

  // present one request and hold it until the block takes it
  task automatic issue_request(input logic f, input logic k, input logic [ADDR_W-1:0] a,
                               input bit typed, input alloc_result_t want);
    alloc_result_t r;
    start       <= 1'b1;
    func        <= f;
    kernel_side <= k;
    page_addr   <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = allocate_or_free(f, k, a);
    expected_grants.push_back(typed ? want : r);
    n_requests++;
  endtask

  // random gap between requests
  task automatic maybe_idle(input bit allow);
    int n;
    if (allow && $urandom_range(99) < 32) begin
      n = $urandom_range(6, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drop start and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] v);
    logic [31:0] upper;
    upper   = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {upper[CFG_DATA_W-ADDR_W-1:0], v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KERNEL_BASE:  kbase  = v;
      REG_KERNEL_LIMIT: klimit = v;
      REG_USER_LIMIT:   ulimit = v;
      default: ;
    endcase
    n_reg_writes++;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[ADDR_W-1:0] !== want) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, want,
               prdata[ADDR_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regions(input logic [ADDR_W-1:0] kb, input logic [ADDR_W-1:0] kl,
                             input logic [ADDR_W-1:0] ul);
    settle();
    write_reg(REG_KERNEL_BASE, kb);
    write_reg(REG_KERNEL_LIMIT, kl);
    write_reg(REG_USER_LIMIT, ul);
    check_reg(REG_KERNEL_BASE, kb);
    check_reg(REG_KERNEL_LIMIT, kl);
    check_reg(REG_USER_LIMIT, ul);
  endtask

  task automatic add_row(input row_kind_t kind, input logic f, input logic k,
                         input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] a,
                         input status_t st, input logic [ADDR_W-1:0] g,
                         input logic [FREE_W-1:0] p);
    stim_row_t row;
    row.kind         = kind;
    row.f            = f;
    row.k            = k;
    row.idx          = idx;
    row.a            = a;
    row.want.status  = st;
    row.want.granted = g;
    row.want.pages   = p;
    directed_rows.push_back(row);
  endtask

  // compare each result with the oldest expected one
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (expected_grants.size() == 0) begin
        $display("%0t: result with no request pending: status %0d addr %h pages %0d",
                 $time, status, granted_addr, pages_free);
        errors++;
      end else begin
        head = expected_grants.pop_front();
        n_by_status[head.status]++;
        if (status !== head.status) begin
          $display("%0t: status expected %0d actual %0d", $time, head.status, status);
          errors++;
        end
        if (granted_addr !== head.granted) begin
          $display("%0t: granted_addr expected %h actual %h", $time, head.granted,
                   granted_addr);
          errors++;
        end
        if (pages_free !== head.pages) begin
          $display("%0t: pages_free expected %0d actual %0d", $time, head.pages,
                   pages_free);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    stim_row_t         row;
    logic              f;
    logic              k;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] kb;
    logic [ADDR_W-1:0] kl;
    logic [ADDR_W-1:0] ul;
    logic [63:0]       r;
    int                kind;
    errors       = 0;
    n_requests   = 0;
    n_results    = 0;
    n_reg_writes = 0;
    n_by_status  = '{0, 0, 0, 0};
    stall_cycles = 0;
    kbase        = KERNEL_BASE_RST;
    klimit       = KERNEL_LIMIT_RST;
    ulimit       = USER_LIMIT_RST;
    kcount       = 0;
    ucount       = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    func         <= FUNC_ALLOC;
    kernel_side  <= USER;
    page_addr    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;

    // reset state, region edges, lifo order, double free
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, KERNEL, REG_SPARE, '0, ST_EMPTY, '0, 16'd0);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, USER, REG_SPARE, '0, ST_EMPTY, '0, 16'd0);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, 56'h8000_0000, ST_OK, '0, 16'd1);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, 56'h803F_F000, ST_OK, '0, 16'd2);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, 56'h8040_0000, ST_BADADDR, '0, 16'd2);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, 56'h8000_0800, ST_BADADDR, '0, 16'd2);
    add_row(ROW_REQ_TYPED, FUNC_FREE, USER, REG_SPARE, 56'h8040_0000, ST_OK, '0, 16'd1);
    add_row(ROW_REQ_TYPED, FUNC_FREE, USER, REG_SPARE, 56'h87FF_F000, ST_OK, '0, 16'd2);
    add_row(ROW_REQ_TYPED, FUNC_FREE, USER, REG_SPARE, 56'h8800_0000, ST_BADADDR, '0, 16'd2);
    add_row(ROW_REQ, FUNC_FREE, USER, REG_SPARE, 56'h803F_F000, ST_OK, '0, '0);
    add_row(ROW_REQ, FUNC_FREE, USER, REG_SPARE, '1, ST_OK, '0, '0);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, KERNEL, REG_SPARE, '0, ST_OK, 56'h803F_F000, 16'd1);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, 56'h8000_0000, ST_OK, '0, 16'd2);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, KERNEL, REG_SPARE, '0, ST_OK, 56'h8000_0000, 16'd1);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, KERNEL, REG_SPARE, '0, ST_OK, 56'h8000_0000, 16'd0);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, KERNEL, REG_SPARE, '0, ST_EMPTY, '0, 16'd0);
    add_row(ROW_REQ, FUNC_ALLOC, USER, REG_SPARE, '1, ST_OK, '0, '0);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, USER, REG_SPARE, '0, ST_OK, 56'h8040_0000, 16'd0);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, USER, REG_SPARE, '0, ST_EMPTY, '0, 16'd0);
    // widest regions, page zero and the topmost page
    add_row(ROW_CFG, FUNC_ALLOC, USER, REG_KERNEL_BASE, '0, ST_OK, '0, '0);
    add_row(ROW_CFG, FUNC_ALLOC, USER, REG_KERNEL_LIMIT, 56'h80_0000_0000_0000, ST_OK, '0, '0);
    add_row(ROW_CFG, FUNC_ALLOC, USER, REG_USER_LIMIT, '1, ST_OK, '0, '0);
    add_row(ROW_CFG, FUNC_ALLOC, USER, REG_SPARE, 56'h12_3456_789A_BCDE, ST_OK, '0, '0);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, '0, ST_OK, '0, 16'd1);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, KERNEL, REG_SPARE, '0, ST_OK, '0, 16'd0);
    add_row(ROW_REQ_TYPED, FUNC_FREE, KERNEL, REG_SPARE, 56'h80_0000_0000_0000,
            ST_BADADDR, '0, 16'd0);
    add_row(ROW_REQ_TYPED, FUNC_FREE, USER, REG_SPARE, 56'hFF_FFFF_FFFF_F000, ST_OK, '0, 16'd1);
    add_row(ROW_REQ_TYPED, FUNC_ALLOC, USER, REG_SPARE, '0, ST_OK, 56'hFF_FFFF_FFFF_F000,
            16'd0);
    add_row(ROW_REQ_TYPED, FUNC_FREE, USER, REG_SPARE, 56'h80_0000_0000_0000, ST_OK, '0, 16'd1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.a);
        if (row.idx != REG_SPARE) check_reg(row.idx, row.a);
      end else begin
        issue_request(row.f, row.k, row.a, row.kind == ROW_REQ_TYPED, row.want);
        maybe_idle(1'b1);
      end
    end

    // random phases, each under its own region setting
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = (ph < 6) ? ph : $urandom_range(5);
      r    = {$urandom, $urandom};
      case (kind)
        0: begin
          kb = KERNEL_BASE_RST;
          kl = KERNEL_LIMIT_RST;
          ul = USER_LIMIT_RST;
        end
        1: begin
          kb = '0;
          kl = 56'h80_0000_0000_0000;
          ul = '1;
        end
        2: begin
          kb = {1'b0, r[ADDR_W-2:PAGE_BITS], {PAGE_BITS{1'b0}}};
          kl = kb + (ADDR_W'($urandom_range(32, 1)) << PAGE_BITS);
          ul = kl + (ADDR_W'($urandom_range(32, 1)) << PAGE_BITS);
        end
        3: begin
          // inverted ranges reject every free
          kl = {2'b01, r[ADDR_W-3:PAGE_BITS], {PAGE_BITS{1'b0}}};
          kb = kl + (ADDR_W'($urandom_range(32, 1)) << PAGE_BITS);
          ul = kl - (ADDR_W'($urandom_range(32, 1)) << PAGE_BITS);
        end
        4: begin
          kb = '0;
          kl = '0;
          ul = '0;
        end
        default: begin
          kb = r[ADDR_W-1:0];
          kl = ADDR_W'({$urandom, $urandom});
          ul = ADDR_W'({$urandom, $urandom});
        end
      endcase
      set_regions(kb, kl, ul);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        f = ($urandom_range(99) < ((ph < 10) ? 55 : 35)) ? FUNC_FREE : FUNC_ALLOC;
        k = 1'($urandom_range(1));
        a = pick_page_addr(k, 1'b0);
        issue_request(f, k, a, 1'b0, '0);
        if ($urandom_range(99) < 2) settle();
        else maybe_idle(ph != 2);
      end
    end

    // drain and report
    settle();
    repeat (8) @(posedge clk);
    $display("%0d requests, %0d results, %0d register writes over directed and random regions",
             n_requests, n_results, n_reg_writes);
    $display("status mix: ok %0d, empty %0d, bad address %0d, overflow %0d",
             n_by_status[ST_OK], n_by_status[ST_EMPTY], n_by_status[ST_BADADDR],
             n_by_status[ST_OVERFLOW]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
